FILE: rtl/dita_pkg.sv
// Shared types and constants for the dotted IPv4 text parser.
package dita_pkg;

   localparam logic [7:0]  DOT_CODE    = 8'd46;
   localparam logic [7:0]  ZERO_CODE   = 8'd48;
   localparam logic [7:0]  NINE_CODE   = 8'd57;
   localparam logic [11:0] GROUP_MAX   = 12'd255;
   localparam int          GROUP_SHIFT = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] DOTS_MAX = 2'd3;

   typedef enum logic [1:0] {
      CLS_DIGIT,
      CLS_DOT,
      CLS_OTHER
   } char_class_type;

   // One classified character as it travels from the front end to the back end.
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           is_last;
      logic           no_text;
   } token_type;

endpackage

FILE: rtl/dita_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
interface dita_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;
   logic       no_text;

   modport source (output valid, output char_code, output is_last, output no_text,
                   input ready);
   modport sink   (input valid, input char_code, input is_last, input no_text,
                   output ready);
endinterface

interface dita_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] address_value;
   logic        is_null;

   modport source (output valid, output address_value, output is_null, input ready);
   modport sink   (input valid, input address_value, input is_null, output ready);
endinterface

FILE: rtl/dotted_ipv4_text_to_integer.sv
// Top level of the dotted-decimal IPv4 text to integer parser.
//
// The block takes one latin1 character per request transfer and returns one
// response transfer per string, on the character marked is_last or on an
// item marked no_text. Digit groups build byte values, dots close groups, and
// short forms with one or two dots are widened as the classic address parser
// does; a malformed character, a group above 255, a trailing dot or an empty
// or absent string give is_null with a zero address. Sustained throughput is
// one character per clock cycle, set by the back end's group update (a
// multiply by ten, an add and a compare), except that a string's last token
// waits while a finished response is held and not taken. A character is
// classified on the way in and lands in a four-entry token queue; the edge
// on which the back end takes a string's last token from the queue also
// loads the response register, so the response passes through the queue and
// then the response register before it is offered. The response register
// lets the front keep taking characters while a finished result waits to be
// taken, and the queue absorbs a short stall of the response side before the
// request side sees one.
module dotted_ipv4_text_to_integer (
   input logic        clock,
   input logic        reset,
   dita_req_if.sink   req,
   dita_rsp_if.source rsp
);
   import dita_pkg::*;

   logic      front_valid, front_ready;
   token_type front_tok;
   logic      back_valid, back_ready;
   token_type back_tok;

   dita_front u_front (
      .req       (req),
      .tok_valid (front_valid),
      .tok       (front_tok),
      .tok_ready (front_ready)
   );

   dita_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_tok),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_tok)
   );

   dita_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (back_valid),
      .tok_ready (back_ready),
      .tok       (back_tok),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   // A null response never carries an address.
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_null |-> rsp.address_value == 64'd0)
      else $error("null response with nonzero address");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid right after reset");

   // An absent string taken by the back end shows up as a null response.
   a_no_text_null: assert property (@(posedge clock) disable iff (reset)
      back_valid && back_ready && back_tok.no_text |=> rsp.valid && rsp.is_null)
      else $error("absent string did not give a null response");

   // A character that does not end its string never produces a response.
   a_mid_quiet: assert property (@(posedge clock) disable iff (reset)
      back_valid && back_ready && !back_tok.no_text && !back_tok.is_last
      && !(rsp.valid && !rsp.ready) |=> !rsp.valid)
      else $error("response produced in the middle of a string");
`endif

endmodule

FILE: rtl/dita_front.sv
// Front end: classifies each incoming character into a token.
module dita_front (
   dita_req_if.sink           req,
   output logic               tok_valid,
   output dita_pkg::token_type tok,
   input  logic               tok_ready
);
   import dita_pkg::*;

   logic is_digit;

   always_comb begin
      is_digit      = (req.char_code >= ZERO_CODE) && (req.char_code <= NINE_CODE);
      tok.digit     = 4'(req.char_code - ZERO_CODE);
      tok.is_last   = req.is_last;
      tok.no_text   = req.no_text;
      if (is_digit) begin
         tok.cls = CLS_DIGIT;
      end else if (req.char_code == DOT_CODE) begin
         tok.cls = CLS_DOT;
      end else begin
         tok.cls = CLS_OTHER;
      end
   end

   assign tok_valid = req.valid;
   assign req.ready = tok_ready;

endmodule

FILE: rtl/dita_queue.sv
// Small token queue between the front end and the back end.
module dita_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  dita_pkg::token_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output dita_pkg::token_type pop_data
);
   import dita_pkg::*;

   token_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff,  count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/dita_back.sv
// Back end: group and address accumulation plus the registered result.
module dita_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   output logic                tok_ready,
   input  dita_pkg::token_type tok,
   dita_rsp_if.source          rsp
);
   import dita_pkg::*;

   logic [7:0]  group_ff, group_in;
   logic [63:0] accum_ff, accum_in;
   logic [1:0]  dots_ff,  dots_in;
   logic        pdot_ff,  pdot_in;
   logic        err_ff,   err_in;

   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_value_ff;
   logic        out_null_ff;

   logic        ends_string, fire;
   logic [11:0] group_next;
   logic [63:0] widened, result;
   logic        result_null;

   assign ends_string = tok.no_text || tok.is_last;
   assign tok_ready   = !ends_string || !out_valid_ff || rsp.ready;
   assign fire        = tok_valid && tok_ready;

   always_comb begin
      group_in   = group_ff;
      accum_in   = accum_ff;
      dots_in    = dots_ff;
      pdot_in    = pdot_ff;
      err_in     = err_ff;
      group_next = {group_ff, 3'b000} + {3'b000, group_ff, 1'b0} + {8'd0, tok.digit};
      if (!err_ff) begin
         unique case (tok.cls)
            CLS_DIGIT: begin
               if (group_next > GROUP_MAX) begin
                  err_in = 1'b1;
               end else begin
                  group_in = group_next[7:0];
               end
               pdot_in = 1'b0;
            end
            CLS_DOT: begin
               accum_in = (accum_ff << GROUP_SHIFT) | {56'd0, group_ff};
               group_in = '0;
               if (dots_ff != DOTS_MAX) begin
                  dots_in = dots_ff + 1'b1;
               end
               pdot_in = 1'b1;
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end

      // Short forms widen the closed groups before the final group goes in.
      unique case (dots_in)
         2'd1:    widened = accum_in << 16;
         2'd2:    widened = accum_in << 8;
         default: widened = accum_in;
      endcase
      result      = (widened << GROUP_SHIFT) | {56'd0, group_in};
      result_null = tok.no_text || err_in || pdot_in;

      out_valid_in = out_valid_ff && !rsp.ready;
      if (fire && ends_string) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff     <= '0;
         accum_ff     <= '0;
         dots_ff      <= '0;
         pdot_ff      <= 1'b1;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            if (ends_string) begin
               group_ff <= '0;
               accum_ff <= '0;
               dots_ff  <= '0;
               pdot_ff  <= 1'b1;
               err_ff   <= 1'b0;
            end else begin
               group_ff <= group_in;
               accum_ff <= accum_in;
               dots_ff  <= dots_in;
               pdot_ff  <= pdot_in;
               err_ff   <= err_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && ends_string) begin
         out_value_ff <= result_null ? 64'd0 : result;
         out_null_ff  <= result_null;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.address_value = out_value_ff;
   assign rsp.is_null       = out_null_ff;

endmodule
